FILE: hw/rtl/parallel_led_bit_waveform_core_defines.svh
// Assertion macros of the parallel LED bit waveform core, used by the slot sequencer.
// Needs clk_i and rst_ni in the scope of every module that uses them.
`ifndef PARALLEL_LED_BIT_WAVEFORM_CORE_DEFINES_SVH
`define PARALLEL_LED_BIT_WAVEFORM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define PLBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define PLBW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PLBW_ASSERT(lbl, prop, msg)
`define PLBW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/plbw_pkg.sv
// Shared widths, register indexes and control types of the LED bit waveform core.
// No dependencies.
package plbw_pkg;

  localparam int unsigned SlotW      = 6;
  localparam int unsigned PlaneW     = 16;
  localparam int unsigned LaneCntW   = 5;
  localparam int unsigned TimingW    = 48;
  localparam int unsigned LaneFieldW = 12;
  localparam int unsigned LanesPerReg = 4;
  localparam int unsigned TimingRegs = 4;
  localparam int unsigned DataW      = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned IdxW       = 3;

  localparam logic [SlotW-1:0]    BitSlotsReset    = 6'd26;
  localparam logic [LaneCntW-1:0] ActiveLanesReset = 5'd16;

  typedef enum logic [IdxW-1:0] {
    REG_BIT_SLOTS    = 3'd0,
    REG_ACTIVE_LANES = 3'd1,
    REG_TIMING_0_3   = 3'd2,
    REG_TIMING_4_7   = 3'd3,
    REG_TIMING_8_11  = 3'd4,
    REG_TIMING_12_15 = 3'd5
  } cfg_reg_e;

  // Control from the slot sequencer to the merge stage.
  typedef struct packed {
    logic emit;
    logic last;
  } seq_ctrl_t;

endpackage

FILE: hw/rtl/plbw_lane.sv
// One lane of the waveform encoder: decides the pin level of its lane in the current slot.
// Depends on plbw_pkg.
module plbw_lane import plbw_pkg::*; (
  input  logic                  data_i,
  input  logic                  enable_i,
  input  logic [LaneFieldW-1:0] timing_i,
  input  logic [SlotW-1:0]      slot_i,
  output logic                  level_o
);

  logic [SlotW-1:0] high_slots;

  // The upper half of the field serves a one bit, the lower half a zero bit.
  assign high_slots = data_i ? timing_i[2*SlotW-1:SlotW] : timing_i[SlotW-1:0];
  assign level_o    = enable_i && (slot_i < high_slots);

endmodule

FILE: hw/rtl/plbw_seq.sv
// Slot sequencer: holds the accepted bit plane and walks the slot index through one bit time.
// Depends on plbw_pkg and the assertion macro header.
`include "parallel_led_bit_waveform_core_defines.svh"
module plbw_seq import plbw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PlaneW-1:0] plane_bits_i,
  input  logic [SlotW-1:0]  slots_i,
  input  logic              load_ok_i,
  output logic [PlaneW-1:0] plane_o,
  output logic [SlotW-1:0]  slot_o,
  output seq_ctrl_t         ctrl_o
);

  logic              busy_q, busy_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [PlaneW-1:0] plane_q, plane_d;
  logic              last_slot;
  logic              emit;
  logic              accept;

  always_comb begin
    last_slot  = (slot_q == SlotW'(slots_i - 6'd1));
    emit       = busy_q && load_ok_i;
    in_ready_o = !busy_q || (emit && last_slot);
    accept     = in_valid_i && in_ready_o;

    busy_d  = busy_q;
    slot_d  = slot_q;
    plane_d = plane_q;
    if (emit) begin
      if (last_slot) begin
        busy_d = 1'b0;
        slot_d = '0;
      end else begin
        slot_d = SlotW'(slot_q + 6'd1);
      end
    end
    // A new plane may start in the cycle that sends the last word of the previous one.
    if (accept) begin
      busy_d  = 1'b1;
      slot_d  = '0;
      plane_d = plane_bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
  end

  assign plane_o     = plane_q;
  assign slot_o      = slot_q;
  assign ctrl_o.emit = emit;
  assign ctrl_o.last = last_slot;

  `PLBW_ASSERT(a_accept_starts_run, (in_valid_i && in_ready_o) |=> (busy_q && slot_q == '0), "accepted plane did not start at slot zero")
  `PLBW_ASSERT(a_slot_steps, (emit && !last_slot && !in_valid_i) |=> (busy_q && slot_q == SlotW'($past(slot_q) + 6'd1)), "slot index did not advance by one")
  `PLBW_ASSERT(a_run_ends, (emit && last_slot && !in_valid_i) |=> !busy_q, "sequencer stayed busy after the last slot")

endmodule

FILE: hw/rtl/plbw_merge.sv
// Merge stage: gathers the lane levels into one slot word and holds it in the output register.
// Depends on plbw_pkg.
module plbw_merge import plbw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PlaneW-1:0] levels_i,
  input  seq_ctrl_t         ctrl_i,
  output logic              load_ok_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PlaneW-1:0] slot_word_o,
  output logic              last_slot_o
);

  logic              valid_q, valid_d;
  logic [PlaneW-1:0] word_q, word_d;
  logic              last_q, last_d;

  assign load_ok_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    last_d  = last_q;
    if (ctrl_i.emit) begin
      valid_d = 1'b1;
      word_d  = levels_i;
      last_d  = ctrl_i.last;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign slot_word_o = word_q;
  assign last_slot_o = last_q;

endmodule

FILE: hw/rtl/parallel_led_bit_waveform_core.sv
// Top level of the parallel LED bit waveform core: register file, slot sequencer, lanes and merge stage.
// Depends on plbw_pkg, plbw_lane, plbw_seq and plbw_merge.
//
// Usage: each word on the input channel (plane_bits_i, in_valid_i/in_ready_o) is one bit plane,
// bit n being the next data bit of LED lane n. For every plane the core sends a run of
// bit_slots words (one if zero, at most MAX_BIT_SLOTS) on the output channel (slot_word_o,
// last_slot_o, out_valid_o/out_ready_i), one per slot of the common bit time; last_slot_o
// marks the final word of the run. A lane is high in slot s while s is below its high-slot
// count, taken from the one-bit or zero-bit half of its timing field. Lanes at or above
// active_lanes stay low. Path: an accepted plane is held in the slot sequencer, and each
// word of its run then passes through the merge stage's output register before it is valid.
// Throughput: one word per cycle while out_ready_i is high; the slot sequencer overlaps the
// acceptance of the next plane with the last word of the current one, so runs follow
// without a gap.
// Reset: bit_slots returns to 26, active_lanes to 16, all timing fields to zero, and the
// core is idle with no word pending.
// Stall: while out_ready_i is low the output register holds its word, the slot index
// waits, and in_ready_o stays low until the last word of the run can be sent.
// The user writes configuration over the APB port only while idle; the core does not check.
module parallel_led_bit_waveform_core import plbw_pkg::*; #(
  parameter int unsigned LANES         = 16,
  parameter int unsigned MAX_BIT_SLOTS = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PlaneW-1:0] plane_bits_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PlaneW-1:0] slot_word_o,
  output logic              last_slot_o
);

  localparam logic [SlotW-1:0]    MaxSlots = SlotW'(MAX_BIT_SLOTS);
  localparam logic [LaneCntW-1:0] MaxLanes = LaneCntW'(LANES);

  // Configuration registers.
  logic [SlotW-1:0]    bit_slots_q;
  logic [LaneCntW-1:0] active_lanes_q;
  logic [TimingW-1:0]  lane_timing_q [TimingRegs];
  cfg_reg_e            reg_idx;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = cfg_reg_e'(paddr[AddrW-1:AddrW-IdxW]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_slots_q    <= BitSlotsReset;
      active_lanes_q <= ActiveLanesReset;
      for (int i = 0; i < TimingRegs; i++) begin
        lane_timing_q[i] <= '0;
      end
    end else if (cfg_write) begin
      case (reg_idx)
        REG_BIT_SLOTS:    bit_slots_q      <= pwdata[SlotW-1:0];
        REG_ACTIVE_LANES: active_lanes_q   <= pwdata[LaneCntW-1:0];
        REG_TIMING_0_3:   lane_timing_q[0] <= pwdata[TimingW-1:0];
        REG_TIMING_4_7:   lane_timing_q[1] <= pwdata[TimingW-1:0];
        REG_TIMING_8_11:  lane_timing_q[2] <= pwdata[TimingW-1:0];
        REG_TIMING_12_15: lane_timing_q[3] <= pwdata[TimingW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BIT_SLOTS:    prdata = DataW'(bit_slots_q);
      REG_ACTIVE_LANES: prdata = DataW'(active_lanes_q);
      REG_TIMING_0_3:   prdata = DataW'(lane_timing_q[0]);
      REG_TIMING_4_7:   prdata = DataW'(lane_timing_q[1]);
      REG_TIMING_8_11:  prdata = DataW'(lane_timing_q[2]);
      REG_TIMING_12_15: prdata = DataW'(lane_timing_q[3]);
      default:          prdata = '0;
    endcase
  end

  // Effective run length and lane count. A zero slot count still sends one word.
  logic [SlotW-1:0]    slots_eff;
  logic [LaneCntW-1:0] lanes_eff;

  always_comb begin
    if (bit_slots_q == '0) begin
      slots_eff = SlotW'(1);
    end else if (bit_slots_q > MaxSlots) begin
      slots_eff = MaxSlots;
    end else begin
      slots_eff = bit_slots_q;
    end
    lanes_eff = (active_lanes_q > MaxLanes) ? MaxLanes : active_lanes_q;
  end

  // Slot sequencer.
  logic              load_ok;
  logic [PlaneW-1:0] plane;
  logic [SlotW-1:0]  slot;
  seq_ctrl_t         seq_ctrl;

  plbw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .plane_bits_i (plane_bits_i),
    .slots_i      (slots_eff),
    .load_ok_i    (load_ok),
    .plane_o      (plane),
    .slot_o       (slot),
    .ctrl_o       (seq_ctrl)
  );

  // One lane per driven pin; pins beyond LANES are tied low.
  logic [PlaneW-1:0] pin_levels;

  for (genvar n = 0; n < PlaneW; n++) begin : g_lane
    if (n < LANES) begin : g_on
      plbw_lane u_lane (
        .data_i   (plane[n]),
        .enable_i (LaneCntW'(n) < lanes_eff),
        .timing_i (lane_timing_q[n / LanesPerReg][LaneFieldW*(n % LanesPerReg) +: LaneFieldW]),
        .slot_i   (slot),
        .level_o  (pin_levels[n])
      );
    end else begin : g_off
      assign pin_levels[n] = 1'b0;
    end
  end

  // Merge stage and output register.
  plbw_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .levels_i    (pin_levels),
    .ctrl_i      (seq_ctrl),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slot_word_o (slot_word_o),
    .last_slot_o (last_slot_o)
  );

endmodule
